// File: hw/rtl/sphere_contact_counter_defines.svh
// Assertion macros for the sphere contact counter checkers.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SPHERE_CONTACT_COUNTER_DEFINES_SVH
`define SPHERE_CONTACT_COUNTER_DEFINES_SVH

// Check an implication in the same cycle, outside reset.
`define SCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, outside reset.
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/scc_pkg.sv
// Shared widths, field offsets and interface structs of the sphere contact counter.
// No dependencies; used by scc_dist_unit and sphere_contact_counter.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  // Field widths
  localparam int IDX_W     = 12;
  localparam int GRP_W     = 32;
  localparam int POS_W     = 32;
  localparam int RAD_W     = 31;
  localparam int DIFF_W    = POS_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int OUT_CNT_W = 16;
  localparam int CFG_W     = 32;

  // Input item layout in tdata, lowest bit first
  localparam int OFS_FIRST_INDEX  = 0;
  localparam int OFS_SECOND_INDEX = OFS_FIRST_INDEX + IDX_W;
  localparam int OFS_FIRST_GROUPS = OFS_SECOND_INDEX + IDX_W;
  localparam int OFS_FIRST_X      = OFS_FIRST_GROUPS + GRP_W;
  localparam int OFS_FIRST_Y      = OFS_FIRST_X + POS_W;
  localparam int OFS_FIRST_Z      = OFS_FIRST_Y + POS_W;
  localparam int OFS_FIRST_R      = OFS_FIRST_Z + POS_W;
  localparam int OFS_SECOND_X     = OFS_FIRST_R + RAD_W;
  localparam int OFS_SECOND_Y     = OFS_SECOND_X + POS_W;
  localparam int OFS_SECOND_Z     = OFS_SECOND_Y + POS_W;
  localparam int OFS_SECOND_R     = OFS_SECOND_Z + POS_W;
  localparam int IN_USED_W        = OFS_SECOND_R + RAD_W;
  localparam int IN_DATA_W        = ((IN_USED_W + 7) / 8) * 8;

  // Result item layout in tdata, lowest bit first
  localparam int OFS_TOUCHING     = 0;
  localparam int OFS_FIRST_COUNT  = 1;
  localparam int OFS_SECOND_COUNT = OFS_FIRST_COUNT + OUT_CNT_W;
  localparam int OUT_USED_W       = OFS_SECOND_COUNT + OUT_CNT_W;
  localparam int OUT_DATA_W       = ((OUT_USED_W + 7) / 8) * 8;

  // Distance test request
  typedef struct packed {
    logic                    start;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] first_z;
    logic        [RAD_W-1:0] first_radius;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [POS_W-1:0] second_z;
    logic        [RAD_W-1:0] second_radius;
  } dist_req_t;

  // Distance test response
  typedef struct packed {
    logic done;
    logic hit;
  } dist_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/scc_dist_unit.sv
// Exact sphere overlap test with one shared squaring multiplier.
// Depends on scc_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module scc_dist_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  scc_pkg::dist_req_t  req_i,
  output scc_pkg::dist_rsp_t  rsp_o
);

  localparam int DIFF_W = scc_pkg::DIFF_W;
  localparam int PROD_W = scc_pkg::PROD_W;
  localparam int ACC_W  = scc_pkg::ACC_W;
  localparam int POS_W  = scc_pkg::POS_W;

  // Step codes of the squaring sequence
  localparam logic [2:0] STEP_X       = 3'd0;
  localparam logic [2:0] STEP_RADIUS  = 3'd3;
  localparam logic [2:0] STEP_STORE_R = 3'd4;
  localparam logic [2:0] STEP_COMPARE = 3'd5;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                 input logic signed [POS_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  logic                   busy_q;
  logic [2:0]             step_q;
  logic                   done_q;
  logic                   hit_q;
  logic [3:0][DIFF_W-1:0] op_q;
  logic [PROD_W-1:0]      prod_q;
  logic [ACC_W-1:0]       d2_q;
  logic [PROD_W-1:0]      r2_q;
  logic [DIFF_W-1:0]      op_sel;
  logic [PROD_W-1:0]      prod_d;

  // Square the operand of the current step
  assign op_sel = op_q[step_q[1:0]];
  assign prod_d = op_sel * op_sel;

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_X;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_X;
      end else if (busy_q) begin
        if (step_q == STEP_COMPARE) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end
    end
  end

  // Operands, products and the running sum of squares
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q[0] <= abs_diff(req_i.first_x, req_i.second_x);
      op_q[1] <= abs_diff(req_i.first_y, req_i.second_y);
      op_q[2] <= abs_diff(req_i.first_z, req_i.second_z);
      op_q[3] <= DIFF_W'(req_i.first_radius) + DIFF_W'(req_i.second_radius);
      d2_q    <= '0;
    end else if (busy_q) begin
      if (step_q <= STEP_RADIUS) begin
        prod_q <= prod_d;
      end
      if (step_q != STEP_X && step_q <= STEP_RADIUS) begin
        d2_q <= d2_q + ACC_W'(prod_q);
      end
      if (step_q == STEP_STORE_R) begin
        r2_q <= prod_q;
      end
      if (step_q == STEP_COMPARE) begin
        hit_q <= (d2_q <= ACC_W'(r2_q));
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hit  = hit_q;

endmodule

`default_nettype wire

// File: hw/rtl/sphere_contact_counter.sv
// Top level of the sphere contact counter: counter store and item sequencer.
// Depends on scc_pkg and scc_dist_unit.
//
// Usage:
//   Input items arrive on the s_axis group; tuser carries func (0 test pair,
//   1 clear counter at first_index). Each item gives one result item on the
//   m_axis group with the touching flag and both counts after the update.
//   The group mask is to be written through cfg_we_i / cfg_wdata_i only while
//   idle; the block itself does not enforce this. Items are handled one at
//   a time. A pair whose groups meet the mask runs six steps of the shared
//   squaring multiplier and compare, then a read-modify-write of each counter
//   through the registered store read. A clear item or a pair outside the
//   mask skips the squaring steps and goes straight to the counter updates.
//   After reset the store is swept to zero, one entry a cycle, all PARTICLES
//   entries; s_axis_tready stays low meanwhile, cfg writes are taken.
//   A stalled receiver holds the result in the output register; the next item
//   is still taken and worked on, and waits for the register before its
//   result is written.
`timescale 1ns / 1ps
`default_nettype none

module sphere_contact_counter #(
  parameter int PARTICLES  = 4096,
  parameter int COUNT_BITS = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // group_select_mask write
  input  wire                            cfg_we_i,
  input  wire  [scc_pkg::CFG_W-1:0]      cfg_wdata_i,
  // input items
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // first_index, second_index, first_groups, first_x, first_y, first_z,
  // first_radius, second_x, second_y, second_z, second_radius, zero pad
  input  wire  [scc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  wire                            s_axis_tuser,
  // result items
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // touching, first_count, second_count, zero pad
  output logic [scc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int AW        = $clog2(PARTICLES);
  localparam int IDX_W     = scc_pkg::IDX_W;
  localparam int OUT_CNT_W = scc_pkg::OUT_CNT_W;
  localparam logic [31:0]           PART_LIM = 32'(PARTICLES);
  localparam logic [AW-1:0]         LAST_ADDR = AW'(PARTICLES - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic {
    FUNC_PAIR  = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_e;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_RD_A  = 8'b0000_1000,
    ST_WR_A  = 8'b0001_0000,
    ST_RD_B  = 8'b0010_0000,
    ST_WR_B  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e                   state_q, state_d;
  logic [AW-1:0]            clr_q, clr_d;
  logic [scc_pkg::CFG_W-1:0] mask_q;
  logic                     out_valid_q;
  logic [OUT_CNT_W-1:0]     out_first_q, out_second_q;
  logic                     out_touch_q;

  // item registers
  func_e                    func_q;
  logic [IDX_W-1:0]         ia_q, ib_q;
  logic                     a_in_q, b_in_q;
  logic                     bump_q, bump_d;
  logic [COUNT_BITS-1:0]    a_val_q, a_val_d;
  logic [OUT_CNT_W-1:0]     res_first_q, res_first_d, res_second_q, res_second_d;

  // counter store
  logic [COUNT_BITS-1:0]    mem [PARTICLES];
  logic [COUNT_BITS-1:0]    rdata_q;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0]    mem_wdata;

  logic                     accept, group_met, load_out;
  logic [IDX_W-1:0]         in_ia, in_ib;
  logic [COUNT_BITS-1:0]    cnt_cur, cnt_new;
  scc_pkg::dist_req_t       dist_req;
  scc_pkg::dist_rsp_t       dist_rsp;

  // Unpack the input item
  assign in_ia     = s_axis_tdata[scc_pkg::OFS_FIRST_INDEX +: IDX_W];
  assign in_ib     = s_axis_tdata[scc_pkg::OFS_SECOND_INDEX +: IDX_W];
  assign group_met = (s_axis_tdata[scc_pkg::OFS_FIRST_GROUPS +: scc_pkg::GRP_W] & mask_q)
                     != '0;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Start the distance test for a pair that meets the mask
  assign dist_req.start = accept && (func_e'(s_axis_tuser) == FUNC_PAIR) && group_met;
  assign dist_req.first_x       = s_axis_tdata[scc_pkg::OFS_FIRST_X +: scc_pkg::POS_W];
  assign dist_req.first_y       = s_axis_tdata[scc_pkg::OFS_FIRST_Y +: scc_pkg::POS_W];
  assign dist_req.first_z       = s_axis_tdata[scc_pkg::OFS_FIRST_Z +: scc_pkg::POS_W];
  assign dist_req.first_radius  = s_axis_tdata[scc_pkg::OFS_FIRST_R +: scc_pkg::RAD_W];
  assign dist_req.second_x      = s_axis_tdata[scc_pkg::OFS_SECOND_X +: scc_pkg::POS_W];
  assign dist_req.second_y      = s_axis_tdata[scc_pkg::OFS_SECOND_Y +: scc_pkg::POS_W];
  assign dist_req.second_z      = s_axis_tdata[scc_pkg::OFS_SECOND_Z +: scc_pkg::POS_W];
  assign dist_req.second_radius = s_axis_tdata[scc_pkg::OFS_SECOND_R +: scc_pkg::RAD_W];

  scc_dist_unit u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dist_req),
    .rsp_o  (dist_rsp)
  );

  // Sequence one item through test, counter updates and result
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    bump_d       = bump_q;
    a_val_d      = a_val_q;
    res_first_d  = res_first_q;
    res_second_d = res_second_q;
    mem_we       = 1'b0;
    mem_waddr    = AW'(ia_q);
    mem_raddr    = AW'(ia_q);
    mem_wdata    = '0;
    cnt_cur      = '0;
    cnt_new      = '0;
    load_out     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          bump_d  = 1'b0;
          state_d = dist_req.start ? ST_MUL : ST_RD_A;
        end
      end
      ST_MUL: begin
        if (dist_rsp.done) begin
          bump_d  = dist_rsp.hit;
          state_d = ST_RD_A;
        end
      end
      ST_RD_A: begin
        mem_raddr = AW'(ia_q);
        state_d   = ST_WR_A;
      end
      ST_WR_A: begin
        cnt_cur = a_in_q ? rdata_q : '0;
        if (func_q == FUNC_CLEAR) begin
          cnt_new = '0;
        end else if (bump_q && cnt_cur != CNT_MAX) begin
          cnt_new = cnt_cur + 1'b1;
        end else begin
          cnt_new = cnt_cur;
        end
        mem_we    = a_in_q && ((func_q == FUNC_CLEAR) || bump_q);
        mem_waddr = AW'(ia_q);
        mem_wdata = cnt_new;
        a_val_d   = cnt_new;
        state_d   = ST_RD_B;
      end
      ST_RD_B: begin
        mem_raddr = AW'(ib_q);
        state_d   = ST_WR_B;
      end
      ST_WR_B: begin
        cnt_cur = b_in_q ? rdata_q : '0;
        if (bump_q && cnt_cur != CNT_MAX) begin
          cnt_new = cnt_cur + 1'b1;
        end else begin
          cnt_new = cnt_cur;
        end
        mem_we       = b_in_q && bump_q;
        mem_waddr    = AW'(ib_q);
        mem_wdata    = cnt_new;
        res_second_d = OUT_CNT_W'(cnt_new);
        // same index twice: first count is the final value too
        res_first_d  = (ia_q == ib_q) ? OUT_CNT_W'(cnt_new) : OUT_CNT_W'(a_val_q);
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      mask_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(s_axis_tuser);
      ia_q   <= in_ia;
      ib_q   <= in_ib;
      a_in_q <= 32'(in_ia) < PART_LIM;
      b_in_q <= 32'(in_ib) < PART_LIM;
    end
    bump_q       <= bump_d;
    a_val_q      <= a_val_d;
    res_first_q  <= res_first_d;
    res_second_q <= res_second_d;
    if (load_out) begin
      out_touch_q  <= bump_q;
      out_first_q  <= res_first_q;
      out_second_q <= res_second_q;
    end
  end

  // Counter store with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(scc_pkg::OUT_DATA_W - scc_pkg::OUT_USED_W){1'b0}},
                          out_second_q, out_first_q, out_touch_q};

endmodule

`default_nettype wire

// File: hw/rtl/scc_checker.sv
// Port-level checks of the sphere contact counter, bound to its top level.
// Depends on sphere_contact_counter_defines.svh and sphere_contact_counter.
`timescale 1ns / 1ps
`default_nettype none
`include "sphere_contact_counter_defines.svh"

module scc_checker #(
  parameter int PARTICLES  = 4096,
  parameter int COUNT_BITS = 16
) (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [scc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam logic FULL_RANGE = (PARTICLES >= 4096) && (COUNT_BITS <= 16);

  // A stalled result stays offered and unchanged
  `SCC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `SCC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed")
  // One item at a time: ready drops right after an accept
  `SCC_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken")
  // A touching pair leaves both counters above zero
  `SCC_ASSERT_NOW(a_touch_count, m_axis_tvalid && m_axis_tdata[0] && FULL_RANGE, (m_axis_tdata[16:1] != '0) && (m_axis_tdata[32:17] != '0), "touch with zero count")

endmodule

bind sphere_contact_counter scc_checker #(
  .PARTICLES  (PARTICLES),
  .COUNT_BITS (COUNT_BITS)
) u_scc_checker (.*);

`default_nettype wire

// File: bench/scc_tb_pkg.sv
// Item layout and operation codes shared by the contact counter bench files.
// Depends on scc_pkg for field widths and tdata offsets.
`timescale 1ns / 1ps

package scc_tb_pkg;
  import scc_pkg::*;

  // Carried on s_axis_tuser
  typedef enum logic {
    FUNC_PAIR  = 1'b0,
    FUNC_CLEAR = 1'b1
  } scc_func_e;

  // One pair item; pack_pair and unpack_pair map it to and from tdata
  typedef struct packed {
    logic        [IDX_W-1:0] first_index;
    logic        [IDX_W-1:0] second_index;
    logic        [GRP_W-1:0] first_groups;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] first_z;
    logic        [RAD_W-1:0] first_radius;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [POS_W-1:0] second_z;
    logic        [RAD_W-1:0] second_radius;
  } pair_item_t;

  function automatic logic [IN_DATA_W-1:0] pack_pair(pair_item_t it);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[OFS_FIRST_INDEX  +: IDX_W] = it.first_index;
    d[OFS_SECOND_INDEX +: IDX_W] = it.second_index;
    d[OFS_FIRST_GROUPS +: GRP_W] = it.first_groups;
    d[OFS_FIRST_X      +: POS_W] = it.first_x;
    d[OFS_FIRST_Y      +: POS_W] = it.first_y;
    d[OFS_FIRST_Z      +: POS_W] = it.first_z;
    d[OFS_FIRST_R      +: RAD_W] = it.first_radius;
    d[OFS_SECOND_X     +: POS_W] = it.second_x;
    d[OFS_SECOND_Y     +: POS_W] = it.second_y;
    d[OFS_SECOND_Z     +: POS_W] = it.second_z;
    d[OFS_SECOND_R     +: RAD_W] = it.second_radius;
    return d;
  endfunction

  function automatic pair_item_t unpack_pair(logic [IN_DATA_W-1:0] d);
    pair_item_t it;
    it.first_index   = d[OFS_FIRST_INDEX  +: IDX_W];
    it.second_index  = d[OFS_SECOND_INDEX +: IDX_W];
    it.first_groups  = d[OFS_FIRST_GROUPS +: GRP_W];
    it.first_x       = d[OFS_FIRST_X      +: POS_W];
    it.first_y       = d[OFS_FIRST_Y      +: POS_W];
    it.first_z       = d[OFS_FIRST_Z      +: POS_W];
    it.first_radius  = d[OFS_FIRST_R      +: RAD_W];
    it.second_x      = d[OFS_SECOND_X     +: POS_W];
    it.second_y      = d[OFS_SECOND_Y     +: POS_W];
    it.second_z      = d[OFS_SECOND_Z     +: POS_W];
    it.second_radius = d[OFS_SECOND_R     +: RAD_W];
    return it;
  endfunction

endpackage

// File: bench/scc_contact_checker.sv
// Checker for the sphere contact counter: tracks the counter store and mask,
// predicts each result item and compares it. Depends on scc_pkg and scc_tb_pkg.
`timescale 1ns / 1ps

module scc_contact_checker #(
  parameter int PARTICLES  = 4096,
  parameter int COUNT_BITS = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [scc_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire                            s_axis_tvalid,
  input  wire                            s_axis_tready,
  input  wire  [scc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  wire                            s_axis_tuser,
  input  wire                            m_axis_tvalid,
  input  wire                            m_axis_tready,
  input  wire  [scc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                             fail_count,
  output int                             pending_count
);
  import scc_pkg::*;
  import scc_tb_pkg::*;

  typedef struct packed {
    logic                 touching;
    logic [OUT_CNT_W-1:0] first_count;
    logic [OUT_CNT_W-1:0] second_count;
  } contact_result_t;

  logic [COUNT_BITS-1:0] contact_tally [PARTICLES];
  logic [CFG_W-1:0]      select_mask;
  contact_result_t       predicted_contacts[$];
  int                    errors = 0;
  int                    backlog = 0;

  assign fail_count    = errors;
  assign pending_count = backlog;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 100) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  function automatic logic [OUT_CNT_W-1:0] read_tally(logic [IDX_W-1:0] idx);
    logic [31:0] v;
    v = (idx < PARTICLES) ? 32'(contact_tally[idx]) : '0;
    return v[OUT_CNT_W-1:0];
  endfunction

  // Saturating increment; indices past the store are ignored
  function automatic void bump_tally(logic [IDX_W-1:0] idx);
    if (idx < PARTICLES && contact_tally[idx] != {COUNT_BITS{1'b1}}) begin
      contact_tally[idx] = contact_tally[idx] + 1'b1;
    end
  endfunction

  // Exact square of a 33-bit difference
  function automatic bit [127:0] square_diff(longint d);
    bit [127:0] m;
    m = 128'((d < 0) ? -d : d);
    return m * m;
  endfunction

  // Apply one item to the store and work out its result
  function automatic contact_result_t predict_contact(scc_func_e op, pair_item_t it);
    contact_result_t res;
    longint          dx, dy, dz;
    bit [127:0]      dist_sq, reach, reach_sq;
    res.touching = 1'b0;
    if (op == FUNC_CLEAR) begin
      if (it.first_index < PARTICLES) contact_tally[it.first_index] = '0;
    end else if ((it.first_groups & select_mask) != '0) begin
      dx = longint'($signed(it.first_x)) - longint'($signed(it.second_x));
      dy = longint'($signed(it.first_y)) - longint'($signed(it.second_y));
      dz = longint'($signed(it.first_z)) - longint'($signed(it.second_z));
      dist_sq  = square_diff(dx) + square_diff(dy) + square_diff(dz);
      reach    = 128'(it.first_radius) + 128'(it.second_radius);
      reach_sq = reach * reach;
      if (dist_sq <= reach_sq) begin
        res.touching = 1'b1;
        bump_tally(it.first_index);
        bump_tally(it.second_index);
      end
    end
    res.first_count  = read_tally(it.first_index);
    res.second_count = read_tally(it.second_index);
    return res;
  endfunction

  // Watch both channels and the mask write at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    contact_result_t got, want;
    if (!rst_ni) begin
      foreach (contact_tally[i]) contact_tally[i] = '0;
      select_mask = '1;
      predicted_contacts.delete();
      backlog <= 0;
    end else begin
      if (cfg_we_i) select_mask = cfg_wdata_i;
      // Compare first: a result never belongs to the item taken in the same cycle
      if (m_axis_tvalid && m_axis_tready) begin
        got.touching     = m_axis_tdata[OFS_TOUCHING];
        got.first_count  = m_axis_tdata[OFS_FIRST_COUNT +: OUT_CNT_W];
        got.second_count = m_axis_tdata[OFS_SECOND_COUNT +: OUT_CNT_W];
        if (predicted_contacts.size() == 0) begin
          report_mismatch("result with no item outstanding", longint'(m_axis_tdata), 0);
        end else begin
          want = predicted_contacts.pop_front();
          if (got.touching != want.touching)
            report_mismatch("touching", got.touching, want.touching);
          if (got.first_count != want.first_count)
            report_mismatch("first_count", got.first_count, want.first_count);
          if (got.second_count != want.second_count)
            report_mismatch("second_count", got.second_count, want.second_count);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_contacts.push_back(
          predict_contact(scc_func_e'(s_axis_tuser), unpack_pair(s_axis_tdata)));
      end
      backlog <= predicted_contacts.size();
    end
  end

endmodule

// File: bench/tb_sphere_contact_counter.sv
// Testbench top for sphere_contact_counter: clock, reset, stimulus, idling
// and verdict. Depends on scc_pkg, scc_tb_pkg and scc_contact_checker.
`timescale 1ns / 1ps

module tb_sphere_contact_counter;
  import scc_pkg::*;
  import scc_tb_pkg::*;

  localparam int ONE_Q          = 65536;       // 1.0 in Q16.16
  localparam int MAX_R          = 32'h7FFF_FFFF;
  localparam int MIN_POS        = 32'h8000_0000;
  localparam int MAX_POS        = 32'h7FFF_FFFF;
  localparam int RX_HOLD_CYCLES = 400;
  // Post-reset sweep clears all 4096 entries with nothing accepted
  localparam int QUIET_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOT_INDEX      = 9;
  localparam int HOT_PAIRS      = 40;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int errors;
  int pending;
  int quiet_cycles = 0;
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;
  bit rx_hold_req  = 1'b0;

  always #2 clk_i = ~clk_i;

  sphere_contact_counter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  scc_contact_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (errors),
    .pending_count (pending)
  );

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pair_item_t make_pair(
    int a_idx, int b_idx, logic [GRP_W-1:0] groups,
    int ax, int ay, int az, int ar, int bx, int by, int bz, int br);
    pair_item_t it;
    it.first_index   = IDX_W'(a_idx);
    it.second_index  = IDX_W'(b_idx);
    it.first_groups  = groups;
    it.first_x       = ax;
    it.first_y       = ay;
    it.first_z       = az;
    it.first_radius  = RAD_W'(ar);
    it.second_x      = bx;
    it.second_y      = by;
    it.second_z      = bz;
    it.second_radius = RAD_W'(br);
    return it;
  endfunction

  // Small index pool most of the time, so counters build up and repeat
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, 7));
    return IDX_W'($urandom_range(0, 4095));
  endfunction

  function automatic logic [GRP_W-1:0] pick_groups();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'h1 << $urandom_range(0, 31);
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Near pairs, wide random pairs, big spheres and exact-boundary pairs
  function automatic pair_item_t random_pair();
    pair_item_t it;
    int         kind, k, r1;
    it.first_index   = pick_index();
    it.second_index  = pick_index();
    it.first_groups  = pick_groups();
    it.first_x       = $urandom;
    it.first_y       = $urandom;
    it.first_z       = $urandom;
    it.second_x      = $urandom;
    it.second_y      = $urandom;
    it.second_z      = $urandom;
    it.first_radius  = RAD_W'($urandom);
    it.second_radius = RAD_W'($urandom);
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      it.second_x      = it.first_x + int'($urandom_range(0, 6 * ONE_Q)) - 3 * ONE_Q;
      it.second_y      = it.first_y + int'($urandom_range(0, 6 * ONE_Q)) - 3 * ONE_Q;
      it.second_z      = it.first_z + int'($urandom_range(0, 6 * ONE_Q)) - 3 * ONE_Q;
      it.first_radius  = RAD_W'($urandom_range(0, 2 * ONE_Q));
      it.second_radius = RAD_W'($urandom_range(0, 2 * ONE_Q));
    end else if (kind < 7) begin
      it.first_radius  = RAD_W'($urandom_range(32'h4000_0000, MAX_R));
      it.second_radius = RAD_W'($urandom_range(32'h4000_0000, MAX_R));
    end else if (kind < 9) begin
      // 3-4-5 triangle, radius sum equal to the distance or one below
      k  = $urandom_range(1, 400000);
      r1 = $urandom_range(0, 5 * k - 1);
      it.second_x      = it.first_x + 3 * k;
      it.second_y      = it.first_y - 4 * k;
      it.second_z      = it.first_z;
      it.first_radius  = RAD_W'(r1);
      it.second_radius = RAD_W'(5 * k - r1 - int'($urandom_range(0, 1)));
    end
    return it;
  endfunction

  // Offer one item and hold it until taken
  task automatic offer_item(input scc_func_e op, input pair_item_t it);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= pack_pair(it);
    do @(posedge clk_i); while (!s_axis_tready);
    gap = tx_gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [CFG_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random(input int count);
    pair_item_t it;
    scc_func_e  op;
    for (int n = 0; n < count; n++) begin
      // Reshuffle idling every hundred items, leaving some stretches clean
      if (n > 0 && n % 100 == 0) begin
        tx_gaps_on   = $urandom_range(0, 3) != 0;
        rx_stalls_on = $urandom_range(0, 3) != 0;
      end
      it = random_pair();
      if ($urandom_range(0, 99) < 12) op = FUNC_CLEAR;
      else op = FUNC_PAIR;
      offer_item(op, it);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mask('1);

    // Directed: boundary, extremes, same index, group miss, clears
    offer_item(FUNC_PAIR, make_pair(0, 1, 1, 0, 0, 0, 2 * ONE_Q,
                                    3 * ONE_Q, 4 * ONE_Q, 0, 3 * ONE_Q));
    offer_item(FUNC_PAIR, make_pair(0, 1, 1, 0, 0, 0, 2 * ONE_Q,
                                    3 * ONE_Q + 1, 4 * ONE_Q, 0, 3 * ONE_Q));
    offer_item(FUNC_PAIR, make_pair(2, 2, '1, 1, 1, 1, 0, 1, 1, 1, 0));
    offer_item(FUNC_PAIR, make_pair(4095, 0, 32'h8000_0000, MIN_POS, MIN_POS, MIN_POS, MAX_R,
                                    MAX_POS, MAX_POS, MAX_POS, MAX_R));
    offer_item(FUNC_PAIR, make_pair(4095, 4095, 1, MIN_POS, 0, 0, MAX_R,
                                    MAX_POS, 0, 0, MAX_R));
    offer_item(FUNC_PAIR, make_pair(4095, 4094, 1, MIN_POS, 0, 0, MAX_R,
                                    MAX_POS - 1, 0, 0, MAX_R));
    offer_item(FUNC_PAIR, make_pair(3, 4, '0, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
    offer_item(FUNC_PAIR, make_pair(5, 6, 2, -3 * ONE_Q, -4 * ONE_Q, -12 * ONE_Q,
                                    6 * ONE_Q, 0, 0, 0, 7 * ONE_Q));
    offer_item(FUNC_PAIR, make_pair(5, 6, 2, -3 * ONE_Q, -4 * ONE_Q - 1, -12 * ONE_Q,
                                    6 * ONE_Q, 0, 0, 0, 7 * ONE_Q));
    offer_item(FUNC_PAIR, make_pair(5, 6, 2, -3 * ONE_Q, -4 * ONE_Q, -12 * ONE_Q,
                                    6 * ONE_Q, 0, 0, 0, 7 * ONE_Q));
    offer_item(FUNC_PAIR, make_pair(4095, 4095, '1, -1, -1, -1, MAX_R,
                                    -1, -1, -1, MAX_R));
    offer_item(FUNC_PAIR, make_pair(1, 0, 4, 0, 0, 0, ONE_Q, 0, ONE_Q, ONE_Q, ONE_Q));
    offer_item(FUNC_CLEAR, make_pair(0, 1, '0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_item(FUNC_CLEAR, make_pair(2, 2, '1, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_item(FUNC_CLEAR, make_pair(4095, 4094, '1, -1, -1, -1, MAX_R,
                                     -1, -1, -1, MAX_R));
    offer_item(FUNC_CLEAR, make_pair(4094, 4095, '1, -1, -1, -1, MAX_R,
                                     -1, -1, -1, MAX_R));
    offer_item(FUNC_PAIR, make_pair(0, 1, 1, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
    offer_item(FUNC_PAIR, make_pair(1, 0, 1, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
    drain();

    // Nothing is tested with an empty mask
    write_mask('0);
    run_random(100);
    drain();

    write_mask(32'h8000_0001);
    run_random(300);
    drain();

    write_mask($urandom);
    run_random(300);
    drain();

    // Back to all groups; receiver holds off while the sender keeps pushing
    write_mask('1);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b1;
    rx_hold_req  = 1'b1;
    run_random(500);
    drain();

    // Hit one counter with same-index pairs back to back, then mix and clear
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    offer_item(FUNC_CLEAR, make_pair(HOT_INDEX, HOT_INDEX + 1, '0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_item(FUNC_CLEAR, make_pair(HOT_INDEX + 1, HOT_INDEX, '0, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat (HOT_PAIRS) begin
      offer_item(FUNC_PAIR, make_pair(HOT_INDEX, HOT_INDEX, 1, 0, 0, 0, ONE_Q,
                                      0, 0, 0, ONE_Q));
    end
    offer_item(FUNC_PAIR, make_pair(HOT_INDEX + 1, HOT_INDEX, 1, 0, 0, 0, ONE_Q,
                                    0, 0, 0, ONE_Q));
    offer_item(FUNC_PAIR, make_pair(HOT_INDEX, HOT_INDEX + 1, 1, 0, 0, 0, ONE_Q,
                                    0, 0, 0, ONE_Q));
    offer_item(FUNC_CLEAR, make_pair(HOT_INDEX, HOT_INDEX + 1, '0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    repeat (32) @(posedge clk_i);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/scc_pkg.sv
hw/rtl/scc_dist_unit.sv
hw/rtl/sphere_contact_counter.sv
hw/rtl/scc_checker.sv
bench/scc_tb_pkg.sv
bench/scc_contact_checker.sv
bench/tb_sphere_contact_counter.sv
